>>> design/iexalu_pkg.sv
`default_nettype none
package iexalu_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned OPW = 5;
	localparam int unsigned DIV_STEPS = 32;
	// Two input stages, one stage per quotient bit, one output stage.
	localparam int unsigned LATENCY = DIV_STEPS + 3;

	typedef logic [OPW-1:0] opcode_t;
	typedef logic [XLEN-1:0] word_t;

	localparam opcode_t OP_CPUID  = 5'd0;
	localparam opcode_t OP_LDHI   = 5'd1;
	localparam opcode_t OP_LDHIO  = 5'd2;
	localparam opcode_t OP_OR     = 5'd3;
	localparam opcode_t OP_NOR    = 5'd4;
	localparam opcode_t OP_AND    = 5'd5;
	localparam opcode_t OP_BIC    = 5'd6;
	localparam opcode_t OP_XOR    = 5'd7;
	localparam opcode_t OP_ADD    = 5'd8;
	localparam opcode_t OP_SUB    = 5'd9;
	localparam opcode_t OP_SEQ    = 5'd10;
	localparam opcode_t OP_SNE    = 5'd11;
	localparam opcode_t OP_SLT    = 5'd12;
	localparam opcode_t OP_SLTU   = 5'd13;
	localparam opcode_t OP_SLE    = 5'd14;
	localparam opcode_t OP_SLEU   = 5'd15;
	localparam opcode_t OP_MIN    = 5'd16;
	localparam opcode_t OP_MAX    = 5'd17;
	localparam opcode_t OP_ASR    = 5'd18;
	localparam opcode_t OP_LSL    = 5'd19;
	localparam opcode_t OP_LSR    = 5'd20;
	localparam opcode_t OP_SHUF   = 5'd21;
	localparam opcode_t OP_CLZ    = 5'd22;
	localparam opcode_t OP_REV    = 5'd23;
	localparam opcode_t OP_PACKB  = 5'd24;
	localparam opcode_t OP_PACKH  = 5'd25;
	localparam opcode_t OP_MUL    = 5'd26;
	localparam opcode_t OP_MULHI  = 5'd27;
	localparam opcode_t OP_MULHIU = 5'd28;
	localparam opcode_t OP_DIV    = 5'd29;
	localparam opcode_t OP_DIVU   = 5'd30;

	localparam word_t LOW13_MASK   = 32'h0000_1fff;
	localparam word_t FEATURE_WORD = 32'h0000_0007;
	localparam word_t ALL_ONES     = 32'hffff_ffff;

endpackage
`default_nettype wire

>>> design/integer_execute_alu_core.sv
// Integer execute ALU: one opcode and two 32-bit operands in, one 32-bit result out.
// Command channel: an item is taken at a rising edge where start is high and busy
// is low. busy is always low, so a new item may be issued in every cycle.
// Result channel: done is high for exactly one cycle while result holds the value
// of one item; results leave in the order the items came in.
// Every opcode takes the same path: two input stages, one stage for each of
// the 32 quotient bits of the pipelined divider, and one output register. All
// operations travel through the same depth so the order is kept without tags.
// Throughput is one item per cycle; the divider retires one quotient bit per
// stage and the 33x33 multiplier sits in a single registered stage.
// The receiver cannot stall, so the pipeline never stops advancing.
// Reset clears all valid bits; items in flight at reset are dropped and no done
// pulse is given until a new item has gone through the full depth.
// cpuid reports the vector length set by LOG2_VECTOR_LENGTH, its log2, or the feature word.
`default_nettype none
module integer_execute_alu_core
	import iexalu_pkg::*;
#(
	parameter int unsigned LOG2_VECTOR_LENGTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [4:0]  opcode,
	input  wire logic [31:0] src_a,
	input  wire logic [31:0] src_b,
	output logic             done,
	output logic [31:0]      result
);

	logic    valid_s1;
	opcode_t op_s1;
	word_t   a_s1, b_s1;

	logic             valid_s2;
	opcode_t          op_s2;
	word_t            simple_s2;
	logic signed [65:0] prod_s2;

	// Divider pipeline, index 0 is the setup stage.
	logic    dv_valid_s3 [0:DIV_STEPS];
	opcode_t dv_op_s3    [0:DIV_STEPS];
	word_t   dv_early_s3 [0:DIV_STEPS];
	word_t   dv_rem_s3   [0:DIV_STEPS];
	word_t   dv_num_s3   [0:DIV_STEPS];
	word_t   dv_den_s3   [0:DIV_STEPS];
	logic    dv_neg_s3   [0:DIV_STEPS];
	logic    dv_zero_s3  [0:DIV_STEPS];

	logic  done_q;
	word_t result_q;

	word_t simple;
	word_t clz_cnt;
	word_t shuf;
	word_t cpuid_val;
	logic  lt_ba_s, lt_ab_s;
	logic  mul_sg;
	logic signed [32:0] ma, mb;
	logic  div_sg;
	word_t na, nb;
	logic [4:0] sh;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= opcode;
		a_s1  <= src_a;
		b_s1  <= src_b;
	end

	always_comb begin
		cpuid_val = 32'd0;
		if (a_s1 == 32'd0) begin
			if (b_s1 == 32'd0)
				cpuid_val = word_t'(1) << LOG2_VECTOR_LENGTH;
			else if (b_s1 == 32'd1)
				cpuid_val = word_t'(LOG2_VECTOR_LENGTH);
			else
				cpuid_val = FEATURE_WORD;
		end else if (a_s1 == 32'd1) begin
			cpuid_val = FEATURE_WORD;
		end
	end

	always_comb begin
		clz_cnt = 32'd32;
		for (int i = 0; i < 32; i++) begin
			if (a_s1[i])
				clz_cnt = word_t'(31 - i);
		end
	end

	always_comb begin
		logic [1:0] sel;
		logic [7:0] byt;
		shuf = '0;
		for (int k = 0; k < 4; k++) begin
			sel = b_s1[3*k +: 2];
			byt = a_s1[8*sel +: 8];
			if (b_s1[3*k+2])
				byt = (b_s1[12] && byt[7]) ? 8'hff : 8'h00;
			shuf[8*k +: 8] = byt;
		end
	end

	assign lt_ba_s = $signed(b_s1) < $signed(a_s1);
	assign lt_ab_s = $signed(a_s1) < $signed(b_s1);
	assign sh = b_s1[4:0];

	always_comb begin
		case (op_s1)
			OP_CPUID:  simple = cpuid_val;
			OP_LDHI:   simple = b_s1 << 13;
			OP_LDHIO:  simple = (b_s1 << 13) | LOW13_MASK;
			OP_OR:     simple = a_s1 | b_s1;
			OP_NOR:    simple = ~(a_s1 | b_s1);
			OP_AND:    simple = a_s1 & b_s1;
			OP_BIC:    simple = a_s1 & ~b_s1;
			OP_XOR:    simple = a_s1 ^ b_s1;
			OP_ADD:    simple = a_s1 + b_s1;
			OP_SUB:    simple = b_s1 - a_s1;
			OP_SEQ:    simple = (b_s1 == a_s1) ? ALL_ONES : '0;
			OP_SNE:    simple = (b_s1 != a_s1) ? ALL_ONES : '0;
			OP_SLT:    simple = lt_ba_s ? ALL_ONES : '0;
			OP_SLTU:   simple = (b_s1 < a_s1) ? ALL_ONES : '0;
			OP_SLE:    simple = lt_ab_s ? '0 : ALL_ONES;
			OP_SLEU:   simple = (b_s1 <= a_s1) ? ALL_ONES : '0;
			OP_MIN:    simple = lt_ba_s ? b_s1 : a_s1;
			OP_MAX:    simple = lt_ab_s ? b_s1 : a_s1;
			OP_ASR:    simple = word_t'($signed(a_s1) >>> sh);
			OP_LSL:    simple = a_s1 << sh;
			OP_LSR:    simple = a_s1 >> sh;
			OP_SHUF:   simple = shuf;
			OP_CLZ:    simple = clz_cnt;
			OP_REV:    simple = {<<{a_s1}};
			OP_PACKB:  simple = {a_s1[23:16], a_s1[7:0], b_s1[23:16], b_s1[7:0]};
			OP_PACKH:  simple = {a_s1[15:0], b_s1[15:0]};
			default:   simple = '0;
		endcase
	end

	assign mul_sg = (op_s1 == OP_MULHI);
	assign ma = {mul_sg & a_s1[31], a_s1};
	assign mb = {mul_sg & b_s1[31], b_s1};

	assign div_sg = (op_s1 == OP_DIV);
	assign na = (div_sg && a_s1[31]) ? (32'd0 - a_s1) : a_s1;
	assign nb = (div_sg && b_s1[31]) ? (32'd0 - b_s1) : b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			dv_valid_s3[0] <= 1'b0;
		end else begin
			valid_s2       <= valid_s1;
			dv_valid_s3[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2          <= op_s1;
		simple_s2      <= simple;
		prod_s2        <= ma * mb;
		dv_op_s3[0]    <= op_s1;
		dv_early_s3[0] <= simple;
		dv_rem_s3[0]   <= '0;
		dv_num_s3[0]   <= na;
		dv_den_s3[0]   <= nb;
		dv_neg_s3[0]   <= div_sg && (a_s1[31] ^ b_s1[31]);
		dv_zero_s3[0]  <= (b_s1 == 32'd0);
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [32:0] trial;
		logic [32:0] diff;
		logic        qbit;
		word_t       early;

		assign trial = {dv_rem_s3[k], dv_num_s3[k][31]};
		assign diff  = trial - {1'b0, dv_den_s3[k]};
		assign qbit  = !diff[32];

		if (k == 0) begin : g_mul
			// The product register lines up with the first quotient stage.
			always_comb begin
				case (op_s2)
					OP_MUL:    early = prod_s2[31:0];
					OP_MULHI:  early = prod_s2[63:32];
					OP_MULHIU: early = prod_s2[63:32];
					default:   early = simple_s2;
				endcase
			end
		end else begin : g_pass
			assign early = dv_early_s3[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid_s3[k+1] <= 1'b0;
			end else begin
				dv_valid_s3[k+1] <= (k == 0) ? valid_s2 : dv_valid_s3[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_op_s3[k+1]    <= dv_op_s3[k];
			dv_early_s3[k+1] <= early;
			dv_rem_s3[k+1]   <= qbit ? diff[31:0] : trial[31:0];
			dv_num_s3[k+1]   <= {dv_num_s3[k][30:0], qbit};
			dv_den_s3[k+1]   <= dv_den_s3[k];
			dv_neg_s3[k+1]   <= dv_neg_s3[k];
			dv_zero_s3[k+1]  <= dv_zero_s3[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid_s3[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (dv_op_s3[DIV_STEPS] == OP_DIV || dv_op_s3[DIV_STEPS] == OP_DIVU) begin
			if (dv_zero_s3[DIV_STEPS])
				result_q <= ALL_ONES;
			else if (dv_neg_s3[DIV_STEPS])
				result_q <= 32'd0 - dv_num_s3[DIV_STEPS];
			else
				result_q <= dv_num_s3[DIV_STEPS];
		end else begin
			result_q <= dv_early_s3[DIV_STEPS];
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("done without a matching start");

	a_sub_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && opcode == OP_SUB, LATENCY))
		|-> result == $past(src_b - src_a, LATENCY))
		else $error("sub result wrong");

	a_divu_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && opcode == OP_DIVU && src_b == 32'd0, LATENCY))
		|-> result == ALL_ONES)
		else $error("divide by zero result wrong");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !busy && ($past(start) == 1'b1))
		else $error("busy raised");
`endif

endmodule
`default_nettype wire
